// ===== hdl/tss_pkg.sv =====
package tss_pkg;

  localparam int CB = 12;          // coordinate width
  localparam int FB = 16;          // fraction bits of a crossing
  localparam int QB = FB + 1;      // quotient bits, quotient is at most 2^FB
  localparam int XW = QB + CB + 2; // crossing width, signed 15.16 with headroom
  localparam int NS = FB + 4;      // setup, FB divide steps, multiply, add, output

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic          hit;
    coord_t        x1;
    logic [CB:0]   dx;   // signed x2 - x1
    logic [CB-1:0] dy;
    logic [CB-1:0] rem;
    logic [QB-1:0] quo;
  } edge_t;

  typedef struct packed {
    coord_t          row;
    edge_t [2:0]     e;
  } div_t;

  typedef struct packed {
    logic          hit;
    coord_t        x1;
    logic [XW-1:0] val;  // product, then crossing
  } lane_t;

  typedef struct packed {
    coord_t      row;
    lane_t [2:0] l;
  } mul_t;

  typedef struct packed {
    coord_t row;
    logic   ok;
    coord_t left;
    coord_t right;
  } span_t;

endpackage

// ===== hdl/tss_setup.sv =====
module tss_setup (
  input  logic            clk,
  input  logic            en,
  input  tss_pkg::coord_t ax,
  input  tss_pkg::coord_t ay,
  input  tss_pkg::coord_t bx,
  input  tss_pkg::coord_t by,
  input  tss_pkg::coord_t cx,
  input  tss_pkg::coord_t cy,
  input  tss_pkg::coord_t row,
  output tss_pkg::div_t   q
);

  function automatic tss_pkg::edge_t edge_init(
    input tss_pkg::coord_t xp, input tss_pkg::coord_t yp,
    input tss_pkg::coord_t xq, input tss_pkg::coord_t yq,
    input tss_pkg::coord_t r,  input tss_pkg::coord_t ymax);
    tss_pkg::coord_t x1;
    tss_pkg::coord_t y1;
    tss_pkg::coord_t x2;
    tss_pkg::coord_t y2;
    logic [tss_pkg::CB:0] dyw;
    logic [tss_pkg::CB:0] dw;
    logic [tss_pkg::CB-1:0] du;
    logic q0;
    tss_pkg::edge_t o;
    if (yp < yq) begin
      x1 = xp; y1 = yp; x2 = xq; y2 = yq;
    end else begin
      x1 = xq; y1 = yq; x2 = xp; y2 = yp;
    end
    o.hit = (yp != yq) &&
            (((r >= y1) && (r < y2)) || ((r == ymax) && (r > y1) && (r <= y2)));
    o.x1  = x1;
    o.dx  = {x2[tss_pkg::CB-1], x2} - {x1[tss_pkg::CB-1], x1};
    dyw   = {y2[tss_pkg::CB-1], y2} - {y1[tss_pkg::CB-1], y1};
    dw    = {r[tss_pkg::CB-1], r} - {y1[tss_pkg::CB-1], y1};
    o.dy  = dyw[tss_pkg::CB-1:0];
    du    = dw[tss_pkg::CB-1:0];
    // top quotient bit: row offset never exceeds the edge height
    q0    = du >= o.dy;
    o.rem = q0 ? du - o.dy : du;
    o.quo = {{(tss_pkg::QB-1){1'b0}}, q0};
    return o;
  endfunction

  tss_pkg::coord_t ymax;
  tss_pkg::div_t   d;

  always_comb begin
    ymax = ay;
    if (by > ymax) ymax = by;
    if (cy > ymax) ymax = cy;
    d.row  = row;
    d.e[0] = edge_init(cx, cy, ax, ay, row, ymax);
    d.e[1] = edge_init(ax, ay, bx, by, row, ymax);
    d.e[2] = edge_init(bx, by, cx, cy, row, ymax);
  end

  always_ff @(posedge clk) begin
    if (en) q <= d;
  end

endmodule

// ===== hdl/tss_div_step.sv =====
module tss_div_step (
  input  logic          clk,
  input  logic          en,
  input  tss_pkg::div_t a,
  output tss_pkg::div_t q
);

  function automatic tss_pkg::edge_t step(input tss_pkg::edge_t e);
    logic [tss_pkg::CB:0] t;
    logic [tss_pkg::CB:0] s;
    logic ge;
    tss_pkg::edge_t o;
    o  = e;
    t  = {e.rem, 1'b0};
    ge = t >= {1'b0, e.dy};
    s  = t - {1'b0, e.dy};
    o.rem = ge ? s[tss_pkg::CB-1:0] : t[tss_pkg::CB-1:0];
    o.quo = {e.quo[tss_pkg::QB-2:0], ge};
    return o;
  endfunction

  tss_pkg::div_t d;

  always_comb begin
    d.row  = a.row;
    d.e[0] = step(a.e[0]);
    d.e[1] = step(a.e[1]);
    d.e[2] = step(a.e[2]);
  end

  always_ff @(posedge clk) begin
    if (en) q <= d;
  end

endmodule

// ===== hdl/tss_resolve.sv =====
module tss_resolve (
  input  logic           clk,
  input  logic [2:0]     en,
  input  tss_pkg::div_t  a,
  output tss_pkg::span_t q
);

  localparam int XW = tss_pkg::XW;
  localparam int FB = tss_pkg::FB;
  localparam int CB = tss_pkg::CB;
  localparam int QB = tss_pkg::QB;

  tss_pkg::mul_t mul;
  tss_pkg::mul_t add;
  tss_pkg::mul_t mul_d;
  tss_pkg::mul_t add_d;
  tss_pkg::span_t span_d;

  logic signed [XW-1:0] x0, x1v, x2v, lo, hi, lv, rv;
  logic ok;

  always_comb begin
    mul_d.row = a.row;
    for (int i = 0; i < 3; i++) begin
      mul_d.l[i].hit = a.e[i].hit;
      mul_d.l[i].x1  = a.e[i].x1;
      mul_d.l[i].val = $signed({{(XW-QB){1'b0}}, a.e[i].quo}) *
                       $signed({{(XW-CB-1){a.e[i].dx[CB]}}, a.e[i].dx});
    end
  end

  always_comb begin
    add_d = mul;
    for (int i = 0; i < 3; i++) begin
      add_d.l[i].val = mul.l[i].val +
        {{(XW-CB-FB){mul.l[i].x1[CB-1]}}, mul.l[i].x1, {FB{1'b0}}};
    end
  end

  always_comb begin
    x0  = add.l[0].val;
    x1v = add.l[1].val;
    x2v = add.l[2].val;
    ok  = 1'b1;
    lo  = x0;
    hi  = x1v;
    // pick the two crossings; with three, drop the largest
    unique case ({add.l[2].hit, add.l[1].hit, add.l[0].hit})
      3'b011: begin lo = x0;  hi = x1v; end
      3'b101: begin lo = x0;  hi = x2v; end
      3'b110: begin lo = x1v; hi = x2v; end
      3'b111: begin
        priority if (x2v >= x0 && x2v >= x1v) begin
          lo = x0; hi = x1v;
        end else if (x1v >= x0) begin
          lo = x0; hi = x2v;
        end else begin
          lo = x1v; hi = x2v;
        end
      end
      default: ok = 1'b0;
    endcase
    if (lo > hi) begin
      lv = hi; hi = lo; lo = lv;
    end
    lv = lo + {{(XW-1){1'b0}}, 1'b1};
    rv = hi - {{(XW-1){1'b0}}, 1'b1};
    span_d.row   = add.row;
    span_d.ok    = ok;
    span_d.left  = ok ? lv[FB+CB-1:FB] + {{(CB-1){1'b0}}, lv[FB-1]} : '0;
    span_d.right = ok ? rv[FB+CB-1:FB] + {{(CB-1){1'b0}}, rv[FB-1]} : '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) mul <= mul_d;
    if (en[1]) add <= add_d;
    if (en[2]) q   <= span_d;
  end

endmodule

// ===== hdl/triangle_scanline_span.sv =====
// Channel  Dir  Bits  Contents
// s        in   88    tdata: ax, ay, bx, by, cx, cy, row
// m        out  40    tdata: row_out, span_left, span_right; tuser: span_valid
//
// One request per cycle while the output is not stalled; the stages are setup,
// 16 divide steps, multiply, add, sort and round.
// The divide runs one quotient bit per stage, which sets the depth.
// Every stage has its own valid bit; a stage loads when it is empty or
// its successor moves, so bubbles close up behind a stalled output.
// rst clears the valid bits only; data registers are not reset.
module triangle_scanline_span (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // ax, ay, bx, by, cx, cy, row, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // row_out, span_left, span_right, zero pad
  output logic [0:0]  m_tuser    // span_valid
);

  localparam int CB = tss_pkg::CB;
  localparam int FB = tss_pkg::FB;
  localparam int NS = tss_pkg::NS;

  logic [NS:0]   rdy;
  logic [NS-1:0] vld;

  tss_pkg::div_t  ds [FB+1];
  tss_pkg::span_t res;

  always_comb begin
    rdy[NS] = m_tready;
    for (int k = NS - 1; k >= 0; k--) rdy[k] = !vld[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  tss_setup u_setup (
    .clk (clk),
    .en  (rdy[0]),
    .ax  (s_tdata[CB-1:0]),
    .ay  (s_tdata[2*CB-1:CB]),
    .bx  (s_tdata[3*CB-1:2*CB]),
    .by  (s_tdata[4*CB-1:3*CB]),
    .cx  (s_tdata[5*CB-1:4*CB]),
    .cy  (s_tdata[6*CB-1:5*CB]),
    .row (s_tdata[7*CB-1:6*CB]),
    .q   (ds[0])
  );

  for (genvar k = 1; k <= FB; k++) begin : g_div
    tss_div_step u_step (
      .clk (clk),
      .en  (rdy[k]),
      .a   (ds[k-1]),
      .q   (ds[k])
    );
  end

  tss_resolve u_resolve (
    .clk (clk),
    .en  (rdy[NS-1:NS-3]),
    .a   (ds[FB]),
    .q   (res)
  );

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];
  assign m_tdata  = {{(40-3*CB){1'b0}}, res.right, res.left, res.row};
  assign m_tuser  = res.ok;

`ifndef SYNTHESIS
  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input stalled with empty output");
  a_take_ready : assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready) else $error("input stalled while output drains");
  a_no_span_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[3*CB-1:CB] == '0))
    else $error("span ends not cleared without a span");
`endif

endmodule

// ===== tb/triangle_scanline_span_test.sv =====
`timescale 1ns / 1ps

typedef struct {
  logic signed [11:0] row;
  logic               ok;
  logic signed [11:0] left;
  logic signed [11:0] right;
} span_exp_t;

class span_board;
  span_exp_t pending[$];
  int        errors;

  function automatic longint rnd_fix(longint v);
    longint fl;
    fl = v >>> 16;
    return fl + ((v >> 15) & 1);
  endfunction

  // build the expected span for one accepted request
  function void note(logic [87:0] d);
    longint vx[3], vy[3], cr[3], r, ymin, ymax, x1, y1, x2, y2, num, quo, t;
    int n, p, e, i, j;
    span_exp_t s;
    n = 0;
    for (e = 0; e < 3; e++) begin
      vx[e] = longint'($signed(d[24*e +: 12]));
      vy[e] = longint'($signed(d[24*e+12 +: 12]));
    end
    r = longint'($signed(d[72 +: 12]));
    ymin = vy[0];
    ymax = vy[0];
    for (e = 1; e < 3; e++) begin
      if (vy[e] < ymin) ymin = vy[e];
      if (vy[e] > ymax) ymax = vy[e];
    end
    for (e = 0; e < 3; e++) begin
      p = (e == 0) ? 2 : e - 1;
      if (vy[p] == vy[e]) continue;
      if (vy[p] < vy[e]) begin
        x1 = vx[p]; y1 = vy[p]; x2 = vx[e]; y2 = vy[e];
      end else begin
        x1 = vx[e]; y1 = vy[e]; x2 = vx[p]; y2 = vy[p];
      end
      if ((r >= y1 && r < y2) || (r == ymax && r > y1 && r <= y2)) begin
        num = 65536 * (r - y1);
        quo = num / (y2 - y1);
        cr[n] = quo * (x2 - x1) + 65536 * x1;
        n++;
      end
    end
    for (i = 0; i < n; i++)
      for (j = i + 1; j < n; j++)
        if (cr[j] < cr[i]) begin
          t = cr[i]; cr[i] = cr[j]; cr[j] = t;
        end
    s.row = r[11:0];
    s.ok = (n >= 2);
    s.left = 0;
    s.right = 0;
    if (n >= 2) begin
      t = rnd_fix(cr[0] + 1);
      s.left = t[11:0];
      t = rnd_fix(cr[1] - 1);
      s.right = t[11:0];
    end
    pending.push_back(s);
  endfunction

  function void check(logic [39:0] d, logic ok);
    span_exp_t s;
    if (pending.size() == 0) begin
      $display("%0t unexpected span: got %h/%b", $time, d, ok);
      errors++;
      return;
    end
    s = pending.pop_front();
    if (d[11:0] !== s.row || ok !== s.ok || d[23:12] !== s.left || d[35:24] !== s.right
        || d[39:36] !== 4'b0) begin
      $display("%0t mismatch: expected row %0d ok %b l %0d r %0d, got row %0d ok %b l %0d r %0d",
               $time, s.row, s.ok, s.left, s.right, $signed(d[11:0]), ok,
               $signed(d[23:12]), $signed(d[35:24]));
      errors++;
    end
  endfunction
endclass

module triangle_scanline_span_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  bit          calm = 0;
  span_board   board;

  triangle_scanline_span uut (.*);

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check(m_tdata, m_tuser[0]);

  always @(negedge clk)
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);

  function automatic logic [11:0] pick();
    case ($urandom_range(5))
      0: return 12'h800;
      1: return 12'h7ff;
      2: return 12'($urandom_range(0, 15) - 8);
      default: return 12'($urandom);
    endcase
  endfunction

  // valid stays high after an accept; idle cycles or the caller drop it
  task automatic send(logic [11:0] ax, ay, bx, by, cx, cy, r);
    if (!calm)
      while ($urandom_range(99) < 32) begin
        s_tvalid <= 0;
        @(negedge clk);
      end
    s_tdata <= {4'b0, r, cy, cx, by, bx, ay, ax};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note(s_tdata);
    @(negedge clk);
  endtask

  task automatic send_rand();
    logic [11:0] v[6];
    logic [11:0] ymn, ymx, r;
    int k;
    for (k = 0; k < 6; k++) v[k] = pick();
    if ($urandom_range(9) < 8) begin
      // most rows fall inside the triangle's y range
      ymn = v[1]; ymx = v[1];
      for (k = 3; k < 6; k += 2) begin
        if ($signed(v[k]) < $signed(ymn)) ymn = v[k];
        if ($signed(v[k]) > $signed(ymx)) ymx = v[k];
      end
      case ($urandom_range(4))
        0: r = ymn;
        1: r = ymx;
        2: r = v[3];
        default: r = 12'(int'($signed(ymn)) +
                         int'($urandom_range(0, int'($signed(ymx)) - int'($signed(ymn)))));
      endcase
    end else r = 12'($urandom);
    send(v[0], v[1], v[2], v[3], v[4], v[5], r);
  endtask

  initial begin
    int i, w;
    board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send(0, 0, 10, 10, 0, 10, 5);
    send(0, 0, 10, 10, 0, 10, 10);
    send(0, 0, 10, 10, 0, 10, 0);
    send(0, 0, 10, 10, 0, 10, 11);
    send(0, 0, 10, 10, 0, 10, 12'hfff);
    send(5, 3, 9, 3, 12'hffc, 3, 3);
    send(12'h800, 12'h800, 12'h7ff, 12'h7ff, 12'h800, 12'h7ff, 12'h7ff);
    send(12'h800, 12'h800, 12'h7ff, 12'h7ff, 12'h800, 12'h7ff, 12'h800);
    send(12'h7ff, 12'h800, 12'h800, 12'h7ff, 12'h7ff, 12'h7ff, 0);
    send(12'h800, 12'h7ff, 12'h7ff, 12'h800, 12'h000, 12'h7ff, 12'h7ff);
    send(0, 0, 1, 1, 1, 0, 0);
    send(0, 0, 0, 5, 1, 5, 4);
    send(3, 12'hff9, 12'hff7, 2, 6, 8, 2);
    send(12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    for (i = 0; i < 1850; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1200) begin
        s_tvalid <= 0;
        w = 0;
        while (board.pending.size() != 0 && w < 10000) begin
          @(posedge clk);
          w++;
        end
        @(negedge clk);
      end
      send_rand();
    end
    s_tvalid <= 0;
    calm = 0;
    w = 0;
    while (board.pending.size() != 0 && w < 100000) begin
      @(posedge clk);
      w++;
    end
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/tss_pkg.sv
hdl/tss_setup.sv
hdl/tss_div_step.sv
hdl/tss_resolve.sv
hdl/triangle_scanline_span.sv
tb/triangle_scanline_span_test.sv
